@@ hw/rtl/tlcf_pkg.sv @@
// Shared types and constants for the two-layer crossfade ramp.
package tlcf_pkg;

    localparam logic [7:0] ALPHA_FULL = 8'hFF;
    localparam logic [7:0] ALPHA_ZERO = 8'h00;

    // Quotient bits from the serial divider; the ramp level never exceeds 8 bits.
    localparam int DIV_STEPS = 8;

    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_RESET   = 2'd1;
    localparam logic [1:0] CMD_REVERSE = 2'd2;
    localparam logic [1:0] CMD_DRAW    = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_START = 2'd1,
        PH_RUN   = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ELAPSED,
        ST_MULT,
        ST_DIVIDE,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] now_ms;
        logic [15:0] duration_ms;
    } in_item_t;

    typedef struct packed {
        logic [7:0] alpha_now;
        logic       ramp_done;
        logic       draw_first;
        logic [7:0] first_alpha;
        logic       draw_second;
        logic [7:0] second_alpha;
        logic       redraw_request;
    } out_item_t;

    typedef struct packed {
        logic latch_in;
        logic calc_elapsed;
        logic load_div;
        logic div_step;
        logic commit;
    } tlcf_cmd_t;

    typedef struct packed {
        logic out_free;
    } tlcf_stat_t;

endpackage

@@ hw/rtl/two_layer_crossfade_ramp.sv @@
// Two-layer crossfade ramp: top level joining sequencer and datapath.
// Acceptance to result valid: elapsed, multiply, 8 divider steps, commit
//   (held while the result register is full); the next request is taken only
//   after commit. The bit-per-cycle restoring divider forms the ramp level.
// Result register lets the next request in while a result is still waiting.
// Reset (rst_n, async, active low): phase idle, all ramp state and cross_fade 0.
module two_layer_crossfade_ramp
    import tlcf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    // cross_fade register
    input  logic      cfg_we,
    input  logic      cfg_data,
    // request channel
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    // result channel
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    tlcf_cmd_t  cmd;
    tlcf_stat_t stat;

    // Sequencer: idle -> elapsed -> multiply -> divide x8 -> commit
    tlcf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Ramp state, arithmetic and the result register
    tlcf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ hw/rtl/tlcf_ctrl.sv @@
// Sequencer for the crossfade ramp: steps one request through the datapath.
module tlcf_ctrl
    import tlcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  tlcf_stat_t stat,
    output tlcf_cmd_t  cmd
);

    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    ctrl_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_ELAPSED;
                end
            end
            ST_ELAPSED:
            begin
                cmd.calc_elapsed = 1'b1;
                state_next       = ST_MULT;
            end
            ST_MULT:
            begin
                cmd.load_div = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_LAST)
                    state_next = ST_FINISH;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/tlcf_datapath.sv @@
// Ramp state, elapsed time, span multiply, serial divider and result register.
module tlcf_datapath
    import tlcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_data,
    input  in_item_t   in_data,
    input  tlcf_cmd_t  cmd,
    output tlcf_stat_t stat,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data
);

    // Configuration and ramp state
    logic        cross_fade_reg;
    phase_t      phase_reg, phase_next;
    logic        reversed_reg, reversed_next;
    logic [31:0] start_time_reg, start_time_next;
    logic [7:0]  ramp_from_reg, ramp_from_next;
    logic [7:0]  ramp_to_reg, ramp_to_next;
    logic [7:0]  level_reg, level_next;
    logic [15:0] ramp_length_reg, ramp_length_next;
    logic [15:0] first_length_reg, first_length_next;

    // Working registers for one request
    in_item_t    req_reg;
    logic [31:0] elapsed_reg;
    logic [16:0] div_rem_reg;
    logic [7:0]  div_low_reg;

    logic        out_valid_reg;
    out_item_t   out_data_reg, out_data_next;

    // Span and dividend
    logic        ramp_up;
    logic [7:0]  span;
    logic [23:0] product;
    logic [24:0] bias;
    logic [24:0] dividend;

    // Divider step
    logic [17:0] div_trial;
    logic [17:0] div_diff;
    logic        div_ge;

    logic        done;

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;

    assign ramp_up  = (ramp_to_reg >= ramp_from_reg);
    assign span     = ramp_up ? (ramp_to_reg - ramp_from_reg) : (ramp_from_reg - ramp_to_reg);
    assign product  = 24'(span) * 24'(elapsed_reg[15:0]);
    // Downward ramps round the step up, so bias the dividend by length - 1.
    assign bias     = ramp_up ? '0 : (25'(ramp_length_reg) - 25'd1);
    assign dividend = 25'(product) + bias;

    assign div_trial = {div_rem_reg, div_low_reg[7]};
    assign div_ge    = (div_trial >= {2'b00, ramp_length_reg});
    assign div_diff  = div_trial - {2'b00, ramp_length_reg};

    always_comb
    begin
        phase_next        = phase_reg;
        reversed_next     = reversed_reg;
        start_time_next   = start_time_reg;
        ramp_from_next    = ramp_from_reg;
        ramp_to_next      = ramp_to_reg;
        level_next        = level_reg;
        ramp_length_next  = ramp_length_reg;
        first_length_next = first_length_reg;
        out_data_next     = '0;
        done              = 1'b0;

        case (req_reg.cmd)
            CMD_START:
            begin
                ramp_from_next    = ALPHA_ZERO;
                ramp_to_next      = ALPHA_FULL;
                level_next        = ALPHA_ZERO;
                reversed_next     = 1'b0;
                ramp_length_next  = req_reg.duration_ms;
                first_length_next = req_reg.duration_ms;
                phase_next        = PH_START;
                out_data_next.redraw_request = 1'b1;
            end
            CMD_RESET:
            begin
                level_next = ALPHA_ZERO;
                phase_next = PH_IDLE;
                out_data_next.redraw_request = 1'b1;
            end
            CMD_REVERSE:
            begin
                if (elapsed_reg > {16'b0, ramp_length_reg})
                begin
                    // Last ramp is over: restart toward the opposite end.
                    if (ramp_to_reg == ALPHA_ZERO)
                    begin
                        ramp_from_next = ALPHA_ZERO;
                        ramp_to_next   = ALPHA_FULL;
                        level_next     = ALPHA_ZERO;
                        reversed_next  = 1'b0;
                    end
                    else
                    begin
                        ramp_from_next = ALPHA_FULL;
                        ramp_to_next   = ALPHA_ZERO;
                        level_next     = ALPHA_FULL;
                        reversed_next  = 1'b1;
                    end
                    ramp_length_next  = req_reg.duration_ms;
                    first_length_next = req_reg.duration_ms;
                    out_data_next.redraw_request = 1'b1;
                end
                else
                begin
                    // Turn around midway from the current level.
                    reversed_next  = !reversed_reg;
                    ramp_from_next = level_reg;
                    ramp_to_next   = reversed_reg ? ALPHA_FULL : ALPHA_ZERO;
                    if (!reversed_reg)
                        ramp_length_next = elapsed_reg[15:0];
                    else if (elapsed_reg[15:0] > first_length_reg)
                        ramp_length_next = '0;
                    else
                        ramp_length_next = first_length_reg - elapsed_reg[15:0];
                end
                phase_next = PH_START;
            end
            CMD_DRAW:
            begin
                done = 1'b1;
                if (phase_reg == PH_START)
                begin
                    start_time_next = req_reg.now_ms;
                    phase_next      = PH_RUN;
                    done            = 1'b0;
                end
                else if (phase_reg == PH_RUN)
                begin
                    if (ramp_length_reg == '0 || elapsed_reg >= {16'b0, ramp_length_reg})
                        level_next = ramp_to_reg;
                    else
                    begin
                        level_next = ramp_up ? (ramp_from_reg + div_low_reg)
                                             : (ramp_from_reg - div_low_reg);
                        done       = 1'b0;
                    end
                end

                if (done)
                begin
                    out_data_next.draw_first  = !cross_fade_reg || (level_next == ALPHA_ZERO);
                    out_data_next.first_alpha = out_data_next.draw_first ? ALPHA_FULL
                                                                         : ALPHA_ZERO;
                    out_data_next.draw_second  = (level_next == ALPHA_FULL);
                    out_data_next.second_alpha = out_data_next.draw_second ? ALPHA_FULL
                                                                           : ALPHA_ZERO;
                end
                else
                begin
                    out_data_next.draw_first   = 1'b1;
                    out_data_next.first_alpha  = cross_fade_reg ? (ALPHA_FULL - level_next)
                                                                : ALPHA_FULL;
                    out_data_next.draw_second  = (level_next != ALPHA_ZERO);
                    out_data_next.second_alpha = level_next;
                    out_data_next.redraw_request = 1'b1;
                end
            end
            default:
            begin
                done = 1'b0;
            end
        endcase

        if (req_reg.cmd == CMD_DRAW)
            out_data_next.ramp_done = done;
        else
            out_data_next.ramp_done = (phase_next == PH_IDLE);
        out_data_next.alpha_now = level_next;
    end

    // Architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cross_fade_reg   <= 1'b0;
            phase_reg        <= PH_IDLE;
            reversed_reg     <= 1'b0;
            start_time_reg   <= '0;
            ramp_from_reg    <= '0;
            ramp_to_reg      <= '0;
            level_reg        <= '0;
            ramp_length_reg  <= '0;
            first_length_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cross_fade_reg <= cfg_data;
            if (cmd.commit)
            begin
                phase_reg        <= phase_next;
                reversed_reg     <= reversed_next;
                start_time_reg   <= start_time_next;
                ramp_from_reg    <= ramp_from_next;
                ramp_to_reg      <= ramp_to_next;
                level_reg        <= level_next;
                ramp_length_reg  <= ramp_length_next;
                first_length_reg <= first_length_next;
                out_valid_reg    <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
            req_reg <= in_data;
        if (cmd.calc_elapsed)
            elapsed_reg <= req_reg.now_ms - start_time_reg;
        if (cmd.load_div)
        begin
            div_rem_reg <= dividend[24:8];
            div_low_reg <= dividend[7:0];
        end
        else if (cmd.div_step)
        begin
            div_rem_reg <= div_ge ? div_diff[16:0] : div_trial[16:0];
            div_low_reg <= {div_low_reg[6:0], div_ge};
        end
        if (cmd.commit)
            out_data_reg <= out_data_next;
    end

endmodule

@@ bench/two_layer_crossfade_ramp_tb.sv @@
// Self-checking bench for the two-layer crossfade ramp: directed and random requests.
module two_layer_crossfade_ramp_tb
    import tlcf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------
    // Scoreboard: carries its own copy of the ramp state, works out the
    // blend for every accepted request and holds it until the block's
    // result turns up.
    // ------------------------------------------------------------------
    class crossfade_scoreboard;
        out_item_t   expected_blend_q[$];
        int unsigned mismatches;

        // mirrored ramp state
        logic        cross_fade;
        phase_t      phase;
        logic        reversed;
        logic [31:0] start_time;
        logic [7:0]  ramp_from;
        logic [7:0]  ramp_to;
        logic [7:0]  level;
        logic [15:0] ramp_length;
        logic [15:0] first_length;

        function new();
            mismatches   = 0;
            cross_fade   = 1'b0;
            phase        = PH_IDLE;
            reversed     = 1'b0;
            start_time   = '0;
            ramp_from    = ALPHA_ZERO;
            ramp_to      = ALPHA_ZERO;
            level        = ALPHA_ZERO;
            ramp_length  = '0;
            first_length = '0;
        endfunction

        function void set_cross_fade(logic value);
            cross_fade = value;
        endfunction

        function int pending();
            return expected_blend_q.size();
        endfunction

        // Fresh ramp: both lengths reloaded, waits for a draw to latch the time.
        function void start_ramp(logic [7:0] from_lvl, logic [7:0] to_lvl, logic rev,
                                 logic [15:0] len);
            ramp_from    = from_lvl;
            ramp_to      = to_lvl;
            level        = from_lvl;
            reversed     = rev;
            ramp_length  = len;
            first_length = len;
            phase        = PH_START;
        endfunction

        function void note_request(in_item_t req);
            out_item_t   blend;
            logic [31:0] elapsed;
            logic [31:0] span;
            logic [31:0] scaled;
            logic        finished;
            blend    = '0;
            finished = 1'b1;
            case (req.cmd)
                CMD_START:
                begin
                    start_ramp(ALPHA_ZERO, ALPHA_FULL, 1'b0, req.duration_ms);
                    blend.redraw_request = 1'b1;
                end
                CMD_RESET:
                begin
                    level = ALPHA_ZERO;
                    phase = PH_IDLE;
                    blend.redraw_request = 1'b1;
                end
                CMD_REVERSE:
                begin
                    elapsed = req.now_ms - start_time;
                    if (elapsed > {16'd0, ramp_length})
                    begin
                        // last ramp is over: restart towards the other end
                        if (ramp_to == ALPHA_ZERO)
                            start_ramp(ALPHA_ZERO, ALPHA_FULL, 1'b0, req.duration_ms);
                        else
                            start_ramp(ALPHA_FULL, ALPHA_ZERO, 1'b1, req.duration_ms);
                        blend.redraw_request = 1'b1;
                    end
                    else
                    begin
                        // turn round from the current level
                        reversed  = !reversed;
                        ramp_from = level;
                        ramp_to   = reversed ? ALPHA_ZERO : ALPHA_FULL;
                        if (reversed)
                            ramp_length = elapsed[15:0];
                        else if (elapsed > {16'd0, first_length})
                            ramp_length = '0;
                        else
                            ramp_length = first_length - elapsed[15:0];
                        phase = PH_START;
                    end
                end
                default:
                begin
                    if (phase == PH_START)
                    begin
                        start_time = req.now_ms;
                        phase      = PH_RUN;
                        finished   = 1'b0;
                    end
                    else if (phase == PH_RUN)
                    begin
                        elapsed = req.now_ms - start_time;
                        if (ramp_length == 0 || elapsed >= {16'd0, ramp_length})
                            level = ramp_to;
                        else
                        begin
                            // rising ramps round down, falling ones round the step up
                            if (ramp_to >= ramp_from)
                            begin
                                span   = {24'd0, ramp_to} - {24'd0, ramp_from};
                                scaled = {24'd0, ramp_from}
                                         + (span * elapsed) / {16'd0, ramp_length};
                            end
                            else
                            begin
                                span   = {24'd0, ramp_from} - {24'd0, ramp_to};
                                scaled = {24'd0, ramp_from}
                                         - (span * elapsed + {16'd0, ramp_length} - 1)
                                           / {16'd0, ramp_length};
                            end
                            level    = scaled[7:0];
                            finished = 1'b0;
                        end
                    end
                    if (finished)
                    begin
                        blend.draw_first   = !cross_fade || level == ALPHA_ZERO;
                        blend.first_alpha  = blend.draw_first ? ALPHA_FULL : ALPHA_ZERO;
                        blend.draw_second  = level == ALPHA_FULL;
                        blend.second_alpha = blend.draw_second ? ALPHA_FULL : ALPHA_ZERO;
                    end
                    else
                    begin
                        blend.draw_first     = 1'b1;
                        blend.first_alpha    = cross_fade ? ALPHA_FULL - level : ALPHA_FULL;
                        blend.draw_second    = level != ALPHA_ZERO;
                        blend.second_alpha   = level;
                        blend.redraw_request = 1'b1;
                    end
                    blend.ramp_done = finished;
                end
            endcase
            if (req.cmd != CMD_DRAW)
                blend.ramp_done = phase == PH_IDLE;
            blend.alpha_now = level;
            expected_blend_q.push_back(blend);
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp_blend;
            logic      bad;
            if (expected_blend_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%t: result with no request outstanding: %p", $realtime, got);
                return;
            end
            exp_blend = expected_blend_q.pop_front();
            bad = got.alpha_now      !== exp_blend.alpha_now
               || got.ramp_done      !== exp_blend.ramp_done
               || got.draw_first     !== exp_blend.draw_first
               || got.first_alpha    !== exp_blend.first_alpha
               || got.draw_second    !== exp_blend.draw_second
               || got.second_alpha   !== exp_blend.second_alpha
               || got.redraw_request !== exp_blend.redraw_request;
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%t: blend mismatch\n  expected %p\n  actual   %p",
                             $realtime, exp_blend, got);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Block and its stimulus signals
    // ------------------------------------------------------------------
    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic      cfg_data;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    crossfade_scoreboard blend_sb = new();

    logic [31:0] clock_ms;   // bench notion of uptime, drives now_ms
    int          sent;       // requests accepted so far
    logic        in_burst;   // sender runs back to back while set
    logic        out_burst;  // receiver never stalls while set

    two_layer_crossfade_ramp DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Both handshakes are observed on the rising edge, before the block's
    // own registers move, so the order of processes within the step is moot.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            blend_sb.note_request(in_data);
        if (rst_n && out_valid && out_ready)
            blend_sb.check_result(out_data);
    end

    // Result side: a stall of random length before each result, with
    // stretches where ready simply stays high.
    initial
    begin
        int unsigned stall;
        out_ready = 1'b0;
        out_burst = 1'b0;
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                out_burst = !out_burst;
            stall = out_burst ? 0 : $urandom_range(0, 15);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && rst_n));
            @(negedge clk);
        end
    end

    // Called on a falling edge; returns on the falling edge after acceptance
    // with valid still high, so a back-to-back request needs only one drive.
    task automatic send_request(input logic [1:0] cmd, input logic [31:0] now,
                                input logic [15:0] dur);
        in_item_t    req;
        int unsigned gap;
        req.cmd         = cmd;
        req.now_ms      = now;
        req.duration_ms = dur;
        if ($urandom_range(0, 39) == 0)
            in_burst = !in_burst;
        gap = in_burst ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        sent++;
    endtask

    // Drop valid, let every outstanding result drain, then allow for the
    // pipeline depth before anything touches the register.
    task automatic settle();
        in_valid <= 1'b0;
        while (blend_sb.pending() != 0)
            @(posedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic write_cross_fade(input logic value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        blend_sb.set_cross_fade(value);
    endtask

    // Short hand-picked run: idle draw, reversal from idle with extreme
    // time and length, wrap of the millisecond counter, a turnaround midway,
    // zero-length ramp, reversal while starting, a draw timed before the
    // start, and resets.
    task automatic directed_requests();
        send_request(CMD_DRAW,    32'h0000_0000, 16'h0000);
        send_request(CMD_REVERSE, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(CMD_DRAW,    32'hFFFF_FFF0, 16'h0000);
        send_request(CMD_DRAW,    32'h0000_0010, 16'hFFFF);
        send_request(CMD_DRAW,    32'h0000_7FF0, 16'h0000);
        send_request(CMD_REVERSE, 32'h0000_8000, 16'd1234);
        send_request(CMD_DRAW,    32'h0000_8000, 16'h0000);
        send_request(CMD_DRAW,    32'h0000_C000, 16'h0000);
        send_request(CMD_DRAW,    32'h0001_0000, 16'h0000);
        send_request(CMD_DRAW,    32'h0002_0000, 16'h0000);
        send_request(CMD_START,   32'd100,       16'd0);
        send_request(CMD_DRAW,    32'd100,       16'h0000);
        send_request(CMD_DRAW,    32'd100,       16'h0000);
        send_request(CMD_REVERSE, 32'd200,       16'd50);
        send_request(CMD_REVERSE, 32'd200,       16'd7);
        send_request(CMD_DRAW,    32'd300,       16'h0000);
        send_request(CMD_DRAW,    32'd303,       16'h0000);
        send_request(CMD_DRAW,    32'd290,       16'h0000);
        send_request(CMD_RESET,   32'd0,         16'h0000);
        send_request(CMD_DRAW,    32'd5,         16'hFFFF);
        send_request(CMD_START,   32'hFFFF_FFFF, 16'hFFFF);
        send_request(CMD_REVERSE, 32'd0,         16'd40000);
        send_request(CMD_DRAW,    32'd1000,      16'h0000);
        send_request(CMD_DRAW,    32'd31000,     16'h0000);
        send_request(CMD_RESET,   32'hFFFF_FFFF, 16'hFFFF);
    endtask

    // One well-formed fade: kick off, latch on the first draw, then a run of
    // draws with the odd turnaround, reset or draw timed before the start.
    task automatic fade_sequence();
        logic [15:0] dur;
        logic [1:0]  kick;
        int          pick;
        int          steps;
        int          stride;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            dur = '0;
        else if (pick < 20)
            dur = 16'($urandom_range(1, 3));
        else if (pick < 85)
            dur = 16'($urandom_range(4, 400));
        else
            dur = 16'($urandom_range(401, 65535));
        if ($urandom_range(0, 9) == 0)
            clock_ms = $urandom;
        else
            clock_ms += $urandom_range(0, 50);
        kick = ($urandom_range(0, 3) == 0) ? CMD_REVERSE : CMD_START;
        send_request(kick, clock_ms, dur);
        if ($urandom_range(0, 9) == 0)
            send_request(CMD_REVERSE, clock_ms + $urandom_range(0, 20),
                         16'($urandom_range(0, 400)));
        clock_ms += $urandom_range(0, 5);
        send_request(CMD_DRAW, clock_ms, 16'($urandom_range(0, 65535)));
        stride = dur / 3 + 2;
        steps  = $urandom_range(2, 12);
        repeat (steps)
        begin
            clock_ms += $urandom_range(0, stride);
            pick = $urandom_range(0, 99);
            if (pick < 12)
            begin
                send_request(CMD_REVERSE, clock_ms, 16'($urandom_range(0, 400)));
                clock_ms += $urandom_range(0, 3);
                send_request(CMD_DRAW, clock_ms, 16'($urandom_range(0, 65535)));
            end
            else if (pick < 15)
                send_request(CMD_RESET, clock_ms, 16'($urandom_range(0, 65535)));
            else if (pick < 20)
                send_request(CMD_DRAW, clock_ms - $urandom_range(1, 100),
                             16'($urandom_range(0, 65535)));
            else
                send_request(CMD_DRAW, clock_ms, 16'($urandom_range(0, 65535)));
        end
    endtask

    task automatic random_requests(input int target);
        while (sent < target)
        begin
            if ($urandom_range(0, 99) < 80)
                fade_sequence();
            else
                repeat ($urandom_range(1, 4))
                    send_request(2'($urandom_range(0, 3)), $urandom,
                                 16'($urandom_range(0, 65535)));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset, directed run with cross fade on, then random
    // phases with the register toggled between them.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_data  = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        in_burst  = 1'b0;
        clock_ms  = '0;
        sent      = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_cross_fade(1'b1);
        directed_requests();
        for (int ph = 0; ph < 5; ph++)
        begin
            settle();
            write_cross_fade(ph[0]);
            random_requests(sent + 385);
        end
        settle();

        if (blend_sb.mismatches == 0 && blend_sb.pending() == 0)
            $display("two_layer_crossfade_ramp_tb passed");
        else
            $display("two_layer_crossfade_ramp_tb failed");
        $finish;
    end

    // Watchdog: well beyond the slowest legal run (about 1 ms).
    initial
    begin
        #5_000_000;
        $display("two_layer_crossfade_ramp_tb failed");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/tlcf_pkg.sv
hw/rtl/tlcf_ctrl.sv
hw/rtl/tlcf_datapath.sv
hw/rtl/two_layer_crossfade_ramp.sv
bench/two_layer_crossfade_ramp_tb.sv
